// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Depends on clock clk and reset rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clk edge outside of reset.
`define CHECK_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define CHECK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/cld_pkg.sv =====
// Types, codes and character constants for the content-length deframer.
// No dependencies.
package cld_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] body_byte;
    logic       last_of_body;
  } out_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_HALT   = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    LS_START,
    LS_MATCH,
    LS_TAIL,
    LS_OTHER,
    LS_VWS,
    LS_VDIG,
    LS_VEND,
    LS_REST
  } line_state_t;

  localparam logic [3:0] NAME_LEN = 4'd14;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] ch);
    return (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) ? ch + 8'd32 : ch;
  endfunction

endpackage

// ===== rtl/content_length_deframer_top.sv =====
// Content-length deframer: header line parser and body pass-through.
// The result of an accepted byte transaction is in the output register in the next cycle.
// Throughput: 1 byte per cycle while result_stall is low; the output register accepts a new byte while being drained.
// Reset (rst, synchronous): header phase, no length, empty output; no clearing pass.
// Halted until reset after end of input, or after a blank line with a bad or missing length.
// Depends on cld_pkg and assert_macros.svh.
module content_length_deframer_top #(
  parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  cld_pkg::in_t  byte_data,
  output logic          result_valid,
  input  logic          result_stall,
  output cld_pkg::out_t result_data
);
  import cld_pkg::*;
  `include "assert_macros.svh"

  phase_t                 phase, phase_next;
  line_state_t            line_state, line_state_next;
  logic [3:0]             name_match_pos, name_match_pos_next;
  logic                   line_nonblank, line_nonblank_next;
  logic                   value_negative, value_negative_next;
  logic                   value_has_digit, value_has_digit_next;
  logic                   value_oversize, value_oversize_next;
  logic [LENGTH_BITS-1:0] value_accum, value_accum_next;
  logic                   have_length, have_length_next;
  logic                   length_oversize, length_oversize_next;
  logic [LENGTH_BITS-1:0] body_length, body_length_next;
  logic [LENGTH_BITS-1:0] body_remaining, body_remaining_next;
  logic                   result_valid_next;
  out_t                   item;

  logic                   accept;
  logic [7:0]             ch;
  logic                   is_blank, is_digit, name_hit;
  logic [3:0]             name_pos_inc;
  logic [LENGTH_BITS+3:0] digit_sum;
  logic                   digit_over;

  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;
  assign ch         = byte_data.in_byte;
  assign is_blank   = (ch == CH_SPACE) || (ch == CH_TAB);
  assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign name_hit   = (name_match_pos < NAME_LEN) && (fold_case(ch) == name_char(name_match_pos));
  assign name_pos_inc = name_match_pos + 4'd1;
  assign digit_sum  = ({4'b0, value_accum} << 3) + ({4'b0, value_accum} << 1)
                    + {{LENGTH_BITS{1'b0}}, ch[3:0]};
  assign digit_over = |digit_sum[LENGTH_BITS+3:LENGTH_BITS];

  always_comb begin
    phase_next           = phase;
    line_state_next      = line_state;
    name_match_pos_next  = name_match_pos;
    line_nonblank_next   = line_nonblank;
    value_negative_next  = value_negative;
    value_has_digit_next = value_has_digit;
    value_oversize_next  = value_oversize;
    value_accum_next     = value_accum;
    have_length_next     = have_length;
    length_oversize_next = length_oversize;
    body_length_next     = body_length;
    body_remaining_next  = body_remaining;
    item                 = '0;
    item.result_kind     = KIND_HEADER;

    if (phase == PH_HALT || (phase != PH_HEADER && phase != PH_BODY)
        || byte_data.end_of_input) begin
      phase_next       = PH_HALT;
      item.result_kind = KIND_HALT;
    end else if (phase == PH_BODY) begin
      item.result_kind = KIND_BODY;
      item.body_byte   = ch;
      if (body_remaining <= LENGTH_BITS'(1)) begin
        item.last_of_body    = 1'b1;
        phase_next           = PH_HEADER;
        line_state_next      = LS_START;
        name_match_pos_next  = '0;
        line_nonblank_next   = 1'b0;
        value_negative_next  = 1'b0;
        value_has_digit_next = 1'b0;
        value_oversize_next  = 1'b0;
        value_accum_next     = '0;
        have_length_next     = 1'b0;
        length_oversize_next = 1'b0;
        body_length_next     = '0;
        body_remaining_next  = '0;
      end else begin
        body_remaining_next = body_remaining - LENGTH_BITS'(1);
      end
    end else if (ch != CH_LF) begin
      if (!is_blank && ch != CH_CR) begin
        line_nonblank_next = 1'b1;
      end
      unique case (line_state)
        LS_START, LS_MATCH: begin
          if (ch == CH_COLON) begin
            line_state_next = LS_REST;
          end else if (line_state == LS_START && is_blank) begin
            line_state_next = LS_START;
          end else if (name_hit) begin
            name_match_pos_next = name_pos_inc;
            line_state_next     = (name_pos_inc >= NAME_LEN) ? LS_TAIL : LS_MATCH;
          end else begin
            line_state_next = LS_OTHER;
          end
        end
        LS_TAIL: begin
          if (ch == CH_COLON) begin
            line_state_next = LS_VWS;
          end else if (!is_blank && ch != CH_CR) begin
            line_state_next = LS_OTHER;
          end
        end
        LS_OTHER: begin
          if (ch == CH_COLON) begin
            line_state_next = LS_REST;
          end
        end
        LS_VWS, LS_VDIG: begin
          if (is_digit) begin
            value_has_digit_next = 1'b1;
            line_state_next      = LS_VDIG;
            if (!value_oversize) begin
              if (digit_over) begin
                value_oversize_next = 1'b1;
              end else begin
                value_accum_next = digit_sum[LENGTH_BITS-1:0];
              end
            end
          end else if (line_state == LS_VDIG) begin
            line_state_next = LS_VEND;
          end else if (is_blank || ch == CH_CR || ch == CH_VT || ch == CH_FF) begin
            line_state_next = LS_VWS;
          end else if (ch == CH_PLUS) begin
            line_state_next = LS_VDIG;
          end else if (ch == CH_MINUS) begin
            value_negative_next = 1'b1;
            line_state_next     = LS_VDIG;
          end else begin
            line_state_next = LS_VEND;
          end
        end
        LS_VEND, LS_REST: begin
        end
        default: begin
        end
      endcase
    end else begin
      line_state_next      = LS_START;
      name_match_pos_next  = '0;
      line_nonblank_next   = 1'b0;
      value_negative_next  = 1'b0;
      value_has_digit_next = 1'b0;
      value_oversize_next  = 1'b0;
      value_accum_next     = '0;
      if (!line_nonblank) begin
        if (!have_length || length_oversize) begin
          phase_next       = PH_HALT;
          item.result_kind = KIND_HALT;
        end else if (body_length == '0) begin
          item.result_kind     = KIND_EMPTY;
          have_length_next     = 1'b0;
          length_oversize_next = 1'b0;
          body_length_next     = '0;
          body_remaining_next  = '0;
        end else begin
          phase_next          = PH_BODY;
          body_remaining_next = body_length;
        end
      end else if (line_state == LS_VWS || line_state == LS_VDIG || line_state == LS_VEND) begin
        if (value_has_digit) begin
          have_length_next     = 1'b1;
          length_oversize_next = value_oversize || (value_negative && value_accum != '0);
          body_length_next     = value_accum;
        end else begin
          have_length_next     = 1'b0;
          length_oversize_next = 1'b0;
          body_length_next     = '0;
        end
      end
    end
  end

  always_comb begin
    result_valid_next = result_valid && result_stall;
    if (accept) begin
      result_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      line_state      <= LS_START;
      name_match_pos  <= '0;
      line_nonblank   <= 1'b0;
      value_negative  <= 1'b0;
      value_has_digit <= 1'b0;
      value_oversize  <= 1'b0;
      value_accum     <= '0;
      have_length     <= 1'b0;
      length_oversize <= 1'b0;
      body_length     <= '0;
      body_remaining  <= '0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
      if (accept) begin
        phase           <= phase_next;
        line_state      <= line_state_next;
        name_match_pos  <= name_match_pos_next;
        line_nonblank   <= line_nonblank_next;
        value_negative  <= value_negative_next;
        value_has_digit <= value_has_digit_next;
        value_oversize  <= value_oversize_next;
        value_accum     <= value_accum_next;
        have_length     <= have_length_next;
        length_oversize <= length_oversize_next;
        body_length     <= body_length_next;
        body_remaining  <= body_remaining_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_data <= item;
    end
  end

  `CHECK_NEXT(a_halt_sticky, phase == PH_HALT, phase == PH_HALT, "halt phase left without reset")
  `CHECK_PROP(a_body_count, (phase != PH_BODY) || (body_remaining != '0), "body phase with zero count")
  `CHECK_NEXT(a_body_result, accept && phase == PH_BODY && !byte_data.end_of_input,
              result_valid && result_data.result_kind == KIND_BODY, "body byte not passed out")
  `CHECK_PROP(a_quiet_fields, !result_valid || result_data.result_kind == KIND_BODY
              || (result_data.body_byte == 8'd0 && !result_data.last_of_body),
              "nonzero fields on a non-body result")

endmodule
